// ===== rtl/dgpq_pkg.sv =====
// Shared constants, codes and types of the dual-gang pot quadrant decoder.
package dgpq_pkg;

    // Pot count and derived index width
    localparam int NUM_POTS  = 4;
    localparam int POT_IDX_W = (NUM_POTS > 1) ? $clog2(NUM_POTS) : 1;

    // Field widths
    localparam int OP_W       = 2;
    localparam int IDX_W      = 4;
    localparam int ADC_W      = 12;
    localparam int VAL_W      = 16;
    localparam int STEP_W     = 15;
    localparam int ST_W       = 2;
    localparam int QUAD_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Operation codes
    localparam logic [OP_W-1:0] OP_SAMPLE = 2'd0;
    localparam logic [OP_W-1:0] OP_SET    = 2'd1;
    localparam logic [OP_W-1:0] OP_LOAD   = 2'd2;

    // Status codes
    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_DEAD_ZONE = 2'd1;
    localparam logic [ST_W-1:0] ST_BAD_INDEX = 2'd2;
    localparam logic [ST_W-1:0] ST_RANGE     = 2'd3;

    // Quadrant codes
    localparam logic [QUAD_W-1:0] QUAD_1 = 2'd0;
    localparam logic [QUAD_W-1:0] QUAD_2 = 2'd1;
    localparam logic [QUAD_W-1:0] QUAD_3 = 2'd2;
    localparam logic [QUAD_W-1:0] QUAD_4 = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ADC1_HALF   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ADC2_HALF   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE_1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE_2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VALUE_MIN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_VALUE_MAX   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_VALUE_STEP  = 3'd6;

    // Settings shared by all pots
    typedef struct packed {
        logic        [ADC_W-1:0]  adc1_half;
        logic        [ADC_W-1:0]  adc2_half;
        logic        [ADC_W-1:0]  dead_zone_1;
        logic        [ADC_W-1:0]  dead_zone_2;
        logic signed [VAL_W-1:0]  value_min;
        logic signed [VAL_W-1:0]  value_max;
        logic        [STEP_W-1:0] value_step;
    } cfg_t;

    // One input beat
    typedef struct packed {
        logic        [OP_W-1:0]  op;
        logic        [IDX_W-1:0] pot_index;
        logic        [ADC_W-1:0] adc1_sample;
        logic        [ADC_W-1:0] adc2_sample;
        logic signed [VAL_W-1:0] new_value;
    } item_t;

    // Stored state of one pot
    typedef struct packed {
        logic signed [VAL_W-1:0]  value;
        logic        [ADC_W-1:0]  last_adc1;
        logic        [ADC_W-1:0]  last_adc2;
        logic        [QUAD_W-1:0] last_quad;
    } pot_t;

    // One result beat
    typedef struct packed {
        logic        [ST_W-1:0]   status;
        logic signed [VAL_W-1:0]  pot_value;
        logic        [QUAD_W-1:0] quadrant;
    } result_t;

    // State write-back for the addressed pot
    typedef struct packed {
        logic                     wr_value;
        logic signed [VAL_W-1:0]  value;
        logic                     wr_track;
        logic        [ADC_W-1:0]  last_adc1;
        logic        [ADC_W-1:0]  last_adc2;
        logic        [QUAD_W-1:0] last_quad;
    } upd_t;

endpackage

// ===== rtl/dgpq_cfg.sv =====
// Configuration register file shared by all pots.
module dgpq_cfg
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dgpq_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dgpq_pkg::CFG_DATA_W-1:0]     cfg_data,
    output dgpq_pkg::cfg_t                      cfg
);
    import dgpq_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Writes are always accepted
    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    // Decode the register index, drop writes beyond the list
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_ADC1_HALF:   cfg_next.adc1_half   = cfg_data[ADC_W-1:0];
                REG_ADC2_HALF:   cfg_next.adc2_half   = cfg_data[ADC_W-1:0];
                REG_DEAD_ZONE_1: cfg_next.dead_zone_1 = cfg_data[ADC_W-1:0];
                REG_DEAD_ZONE_2: cfg_next.dead_zone_2 = cfg_data[ADC_W-1:0];
                REG_VALUE_MIN:   cfg_next.value_min   = $signed(cfg_data[VAL_W-1:0]);
                REG_VALUE_MAX:   cfg_next.value_max   = $signed(cfg_data[VAL_W-1:0]);
                REG_VALUE_STEP:  cfg_next.value_step  = cfg_data[STEP_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.adc1_half   <= ADC_W'(2047);
            cfg_reg.adc2_half   <= ADC_W'(2047);
            cfg_reg.dead_zone_1 <= ADC_W'(16);
            cfg_reg.dead_zone_2 <= ADC_W'(16);
            cfg_reg.value_min   <= VAL_W'(0);
            cfg_reg.value_max   <= VAL_W'(1000);
            cfg_reg.value_step  <= STEP_W'(1);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== rtl/dgpq_step.sv =====
// Single-pass decode of one beat against the addressed pot's state.
module dgpq_step
(
    input  dgpq_pkg::cfg_t    cfg,
    input  dgpq_pkg::item_t   item,
    input  dgpq_pkg::pot_t    pot,
    output dgpq_pkg::result_t result,
    output dgpq_pkg::upd_t    upd
);
    import dgpq_pkg::*;

    logic                     bad_index;
    logic [QUAD_W-1:0]        quad;
    logic                     track2;
    logic signed [ADC_W+1:0]  trk_sample;
    logic signed [ADC_W+1:0]  trk_last;
    logic signed [ADC_W+1:0]  trk_dz;
    logic                     reject;
    logic                     up1;
    logic                     up2;
    logic                     inc;
    logic signed [VAL_W:0]    val_ext;
    logic signed [VAL_W:0]    step_ext;
    logic signed [VAL_W:0]    sum;
    logic signed [VAL_W:0]    diff;
    logic signed [VAL_W-1:0]  stepped;
    logic                     in_range;

    assign bad_index = {1'b0, item.pot_index} >= (IDX_W+1)'(NUM_POTS);

    // Quadrant search, first matching test wins
    always_comb
    begin
        if (item.adc1_sample <= cfg.adc1_half && item.adc2_sample >= cfg.adc2_half)
            quad = QUAD_1;
        else if (item.adc1_sample >= cfg.adc1_half && item.adc2_sample >= cfg.adc2_half)
            quad = QUAD_2;
        else if (item.adc1_sample >= cfg.adc1_half && item.adc2_sample <= cfg.adc2_half)
            quad = QUAD_3;
        else
            quad = QUAD_4;
    end

    // Dead zone on the channel this quadrant tracks (strict bounds)
    assign track2     = (quad == QUAD_1) || (quad == QUAD_4);
    assign trk_sample = $signed({2'b00, track2 ? item.adc2_sample : item.adc1_sample});
    assign trk_last   = $signed({2'b00, track2 ? pot.last_adc2 : pot.last_adc1});
    assign trk_dz     = $signed({2'b00, track2 ? cfg.dead_zone_2 : cfg.dead_zone_1});
    assign reject     = (trk_sample > trk_last - trk_dz) && (trk_sample < trk_last + trk_dz);

    // Direction from channel change or from the quadrant just left
    assign up1 = item.adc1_sample > pot.last_adc1;
    assign up2 = item.adc2_sample > pot.last_adc2;

    always_comb
    begin
        case (quad)
            QUAD_1:  inc = up2 || (pot.last_quad == QUAD_4);
            QUAD_2:  inc = up1 || (pot.last_quad == QUAD_1);
            QUAD_3:  inc = !up1 || (pot.last_quad == QUAD_2);
            default: inc = up2 || (pot.last_quad == QUAD_3);
        endcase
    end

    // Saturating step between min and max
    assign val_ext  = {pot.value[VAL_W-1], pot.value};
    assign step_ext = $signed({2'b00, cfg.value_step});
    assign sum      = val_ext + step_ext;
    assign diff     = val_ext - step_ext;

    always_comb
    begin
        stepped = pot.value;
        if (inc)
        begin
            if (pot.value < cfg.value_max)
                stepped = (sum > $signed({cfg.value_max[VAL_W-1], cfg.value_max}))
                          ? cfg.value_max : sum[VAL_W-1:0];
        end
        else
        begin
            if (pot.value > cfg.value_min)
                stepped = (diff < $signed({cfg.value_min[VAL_W-1], cfg.value_min}))
                          ? cfg.value_min : diff[VAL_W-1:0];
        end
    end

    assign in_range = (item.new_value >= cfg.value_min) && (item.new_value <= cfg.value_max);

    // Result and write-back per operation
    always_comb
    begin
        result.status    = ST_OK;
        result.pot_value = pot.value;
        result.quadrant  = pot.last_quad;
        upd.wr_value     = 1'b0;
        upd.value        = pot.value;
        upd.wr_track     = 1'b0;
        upd.last_adc1    = item.adc1_sample;
        upd.last_adc2    = item.adc2_sample;
        upd.last_quad    = quad;
        if (bad_index)
        begin
            result.status    = ST_BAD_INDEX;
            result.pot_value = '0;
            result.quadrant  = QUAD_1;
        end
        else
        begin
            case (item.op)
                OP_SAMPLE:
                begin
                    result.quadrant = quad;
                    if (reject)
                    begin
                        result.status = ST_DEAD_ZONE;
                    end
                    else
                    begin
                        result.pot_value = stepped;
                        upd.wr_value     = 1'b1;
                        upd.value        = stepped;
                        upd.wr_track     = 1'b1;
                    end
                end
                OP_SET:
                begin
                    if (in_range)
                    begin
                        result.pot_value = item.new_value;
                        upd.wr_value     = 1'b1;
                        upd.value        = item.new_value;
                    end
                    else
                    begin
                        result.status = ST_RANGE;
                    end
                end
                OP_LOAD:
                begin
                    result.pot_value = item.new_value;
                    result.quadrant  = QUAD_1;
                    upd.wr_value     = 1'b1;
                    upd.value        = item.new_value;
                    upd.wr_track     = 1'b1;
                    upd.last_quad    = QUAD_1;
                end
                default:
                begin
                    result.status = ST_OK;
                end
            endcase
        end
    end

endmodule

// ===== rtl/dual_gang_pot_quadrant_decoder_core.sv =====
// Top level: input register, per-pot state, single-pass decode, result register.
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------------
//  s_*      | s_tvalid / s_tready  | s_tuser op, s_tdata index/adc1/adc2/new_value
//  m_*      | m_tvalid / m_tready  | m_tuser status, m_tdata pot_value/quadrant
//  cfg_*    | cfg_valid/cfg_ready  | cfg_index register number, cfg_data value
//
// One beat per cycle sustained while m_tready stays high; an accepted input beat is held in the
// input register, decoded from there and then registered in the result register.
// The decode reads and writes the per-pot registers in the same cycle, so a beat
// always sees the state left by the one before it.
// Reset clears the settings to their defaults and every pot to zero in quadrant Q1.
// A stalled result holds the input register; s_tready drops only when both are full.
module dual_gang_pot_quadrant_decoder_core
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [47:0]                         s_tdata,   // pot_index, adc1_sample, adc2_sample, new_value, zero pad
    input  logic [1:0]                          s_tuser,   // op
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [23:0]                         m_tdata,   // pot_value, quadrant, zero pad
    output logic [1:0]                          m_tuser,   // status
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dgpq_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dgpq_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import dgpq_pkg::*;

    cfg_t                    cfg;
    item_t                   in_item;
    item_t                   in_item_reg;
    logic                    in_valid_reg;
    logic                    in_valid_next;
    result_t                 out_result_reg;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic                    advance;
    logic [POT_IDX_W-1:0]    pidx;
    pot_t                    pot;
    result_t                 result;
    upd_t                    upd;

    logic signed [VAL_W-1:0]  pot_value_reg [NUM_POTS];
    logic        [ADC_W-1:0]  last_adc1_reg [NUM_POTS];
    logic        [ADC_W-1:0]  last_adc2_reg [NUM_POTS];
    logic        [QUAD_W-1:0] last_quad_reg [NUM_POTS];

    // Settings
    dgpq_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Unpack the input beat
    assign in_item.op          = s_tuser;
    assign in_item.pot_index   = s_tdata[3:0];
    assign in_item.adc1_sample = s_tdata[15:4];
    assign in_item.adc2_sample = s_tdata[27:16];
    assign in_item.new_value   = $signed(s_tdata[43:28]);

    // Handshake: advance when the result register is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the input beat
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_item_reg <= in_item;
    end

    // Read the addressed pot
    assign pidx          = in_item_reg.pot_index[POT_IDX_W-1:0];
    assign pot.value     = pot_value_reg[pidx];
    assign pot.last_adc1 = last_adc1_reg[pidx];
    assign pot.last_adc2 = last_adc2_reg[pidx];
    assign pot.last_quad = last_quad_reg[pidx];

    dgpq_step u_step
    (
        .cfg    (cfg),
        .item   (in_item_reg),
        .pot    (pot),
        .result (result),
        .upd    (upd)
    );

    // Write back pot state as the beat moves to the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_POTS; i++)
            begin
                pot_value_reg[i] <= '0;
                last_adc1_reg[i] <= '0;
                last_adc2_reg[i] <= '0;
                last_quad_reg[i] <= QUAD_1;
            end
        end
        else if (advance)
        begin
            if (upd.wr_value)
                pot_value_reg[pidx] <= upd.value;
            if (upd.wr_track)
            begin
                last_adc1_reg[pidx] <= upd.last_adc1;
                last_adc2_reg[pidx] <= upd.last_adc2;
                last_quad_reg[pidx] <= upd.last_quad;
            end
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (advance)
            out_result_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_result_reg.status;
    assign m_tdata  = {6'b0, out_result_reg.quadrant, out_result_reg.pot_value};

    // A decoded beat always shows up at the output next cycle
    assert property (@(posedge clk) disable iff (!rst_n) advance |=> m_tvalid)
        else $error("decoded beat did not reach the result register");

    // Input back-pressure only when both registers are full and the sink stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled without a full pipeline");

    // Bad index results carry zero value and quadrant
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == ST_BAD_INDEX) |-> (m_tdata == 24'd0))
        else $error("bad index result carries data");

endmodule

// ===== tb/sv/dgpq_decode_check.sv =====
// Decode checker: watches all three channels, predicts each result and compares it.
module dgpq_decode_check
    import dgpq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [47:0]           s_tdata,   // pot_index, adc1_sample, adc2_sample, new_value, zero pad
    input  logic [1:0]            s_tuser,   // op
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [23:0]           m_tdata,   // pot_value, quadrant, zero pad
    input  logic [1:0]            m_tuser,   // status
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    pending,
    output int                    result_count,
    output int                    reject_count
);

    cfg_t    settings;
    pot_t    pots [NUM_POTS];
    result_t want_results [$];

    // True when a reading lies strictly within the dead zone around the last one
    function automatic logic near_last(int reading, int last, int zone);
        return (reading > last - zone) && (reading < last + zone);
    endfunction

    // Predict one result beat and advance the pot state it touches
    function automatic result_t decode_item(item_t it);
        result_t            r;
        pot_t               p;
        logic [QUAD_W-1:0]  q;
        logic               rej;
        logic               inc;
        logic               up1;
        logic               up2;
        int                 idx;
        int                 v;
        int                 vmin;
        int                 vmax;
        int                 stp;
        int                 nv;

        r = '0;
        r.status = ST_OK;
        if (it.pot_index >= NUM_POTS) begin
            r.status = ST_BAD_INDEX;
            return r;
        end
        idx  = it.pot_index;
        p    = pots[idx];
        vmin = $signed(settings.value_min);
        vmax = $signed(settings.value_max);
        stp  = int'(settings.value_step);
        nv   = $signed(it.new_value);

        if (it.op == OP_SAMPLE) begin
            up1 = it.adc1_sample > p.last_adc1;
            up2 = it.adc2_sample > p.last_adc2;
            if (it.adc1_sample <= settings.adc1_half && it.adc2_sample >= settings.adc2_half)
                q = QUAD_1;
            else if (it.adc1_sample >= settings.adc1_half && it.adc2_sample >= settings.adc2_half)
                q = QUAD_2;
            else if (it.adc1_sample >= settings.adc1_half && it.adc2_sample <= settings.adc2_half)
                q = QUAD_3;
            else
                q = QUAD_4;

            // Q1 and Q4 follow channel 2, Q2 and Q3 follow channel 1
            if (q == QUAD_1 || q == QUAD_4)
                rej = near_last(it.adc2_sample, p.last_adc2, settings.dead_zone_2);
            else
                rej = near_last(it.adc1_sample, p.last_adc1, settings.dead_zone_1);

            if (rej) begin
                r.status = ST_DEAD_ZONE;
            end
            else begin
                case (q)
                    QUAD_1:  inc = up2 || p.last_quad == QUAD_4;
                    QUAD_2:  inc = up1 || p.last_quad == QUAD_1;
                    QUAD_3:  inc = !up1 || p.last_quad == QUAD_2;
                    default: inc = up2 || p.last_quad == QUAD_3;
                endcase
                v = $signed(p.value);
                // Step toward the bound, clamping at it
                if (inc) begin
                    if (v < vmax) begin
                        v = v + stp;
                        if (v > vmax)
                            v = vmax;
                    end
                end
                else begin
                    if (v > vmin) begin
                        v = v - stp;
                        if (v < vmin)
                            v = vmin;
                    end
                end
                p.value     = v[VAL_W-1:0];
                p.last_quad = q;
                p.last_adc1 = it.adc1_sample;
                p.last_adc2 = it.adc2_sample;
            end
        end
        else if (it.op == OP_SET) begin
            if (nv >= vmin && nv <= vmax)
                p.value = it.new_value;
            else
                r.status = ST_RANGE;
            q = p.last_quad;
        end
        else if (it.op == OP_LOAD) begin
            p.value     = it.new_value;
            p.last_adc1 = it.adc1_sample;
            p.last_adc2 = it.adc2_sample;
            p.last_quad = QUAD_1;
            q           = QUAD_1;
        end
        else begin
            q = p.last_quad;
        end

        pots[idx]   = p;
        r.pot_value = p.value;
        r.quadrant  = q;
        return r;
    endfunction

    // Track settings, queue predictions, compare result beats
    always @(posedge clk or negedge rst_n) begin
        item_t   it;
        result_t got;
        result_t want;

        if (!rst_n) begin
            settings.adc1_half   = 12'd2047;
            settings.adc2_half   = 12'd2047;
            settings.dead_zone_1 = 12'd16;
            settings.dead_zone_2 = 12'd16;
            settings.value_min   = 16'sd0;
            settings.value_max   = 16'sd1000;
            settings.value_step  = 15'd1;
            foreach (pots[i])
                pots[i] = '0;
            want_results.delete();
            fail_count   = 0;
            pending      = 0;
            result_count = 0;
            reject_count = 0;
        end
        else begin
            // Compare an accepted result beat with the oldest prediction
            if (m_tvalid && m_tready) begin
                got.status    = m_tuser;
                got.pot_value = m_tdata[15:0];
                got.quadrant  = m_tdata[17:16];
                result_count++;
                if (want_results.size() == 0) begin
                    $error("unexpected result beat: status %0d pot_value %0d quadrant %0d",
                           got.status, $signed(got.pot_value), got.quadrant);
                    fail_count++;
                end
                else begin
                    want = want_results.pop_front();
                    if (got.status !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, got.status);
                        fail_count++;
                    end
                    if (got.pot_value !== want.pot_value) begin
                        $error("pot_value mismatch: expected %0d, actual %0d",
                               $signed(want.pot_value), $signed(got.pot_value));
                        fail_count++;
                    end
                    if (got.quadrant !== want.quadrant) begin
                        $error("quadrant mismatch: expected %0d, actual %0d",
                               want.quadrant, got.quadrant);
                        fail_count++;
                    end
                end
            end

            // Follow register writes
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_ADC1_HALF:   settings.adc1_half   = cfg_data[ADC_W-1:0];
                    REG_ADC2_HALF:   settings.adc2_half   = cfg_data[ADC_W-1:0];
                    REG_DEAD_ZONE_1: settings.dead_zone_1 = cfg_data[ADC_W-1:0];
                    REG_DEAD_ZONE_2: settings.dead_zone_2 = cfg_data[ADC_W-1:0];
                    REG_VALUE_MIN:   settings.value_min   = cfg_data[VAL_W-1:0];
                    REG_VALUE_MAX:   settings.value_max   = cfg_data[VAL_W-1:0];
                    REG_VALUE_STEP:  settings.value_step  = cfg_data[STEP_W-1:0];
                    default: ;
                endcase
            end

            // Predict the result of an accepted input beat
            if (s_tvalid && s_tready) begin
                it.op          = s_tuser;
                it.pot_index   = s_tdata[3:0];
                it.adc1_sample = s_tdata[15:4];
                it.adc2_sample = s_tdata[27:16];
                it.new_value   = s_tdata[43:28];
                want = decode_item(it);
                if (want.status == ST_DEAD_ZONE)
                    reject_count++;
                want_results.push_back(want);
            end
            pending = want_results.size();
        end
    end

endmodule

// ===== tb/sv/testbench.sv =====
// Testbench top: clock, reset, stimulus, receiver stalls, watchdog and verdict.
module testbench;
    import dgpq_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED      = 2'd3;
    localparam int              WATCHDOG_LIMIT = 5000;
    localparam int              LONG_HOLD      = 80;
    localparam int              PHASE_ITEMS    = 250;
    localparam int              TURN_PERIOD    = 16384;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [47:0]           s_tdata   = '0;   // pot_index, adc1_sample, adc2_sample, new_value, zero pad
    logic [1:0]            s_tuser   = '0;   // op
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [23:0]           m_tdata;          // pot_value, quadrant, zero pad
    logic [1:0]            m_tuser;          // status
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int    fail_count;
    int    pending;
    int    result_count;
    int    reject_count;
    int    items_sent  = 0;
    int    cfg_writes  = 0;
    int    idle_cycles = 0;
    int    stall_mode  = 0;
    logic  long_hold_req = 1'b0;
    int    hold_left   = 0;
    int    rx_cycle    = 0;
    int    vmin_set    = 0;
    int    vmax_set    = 1000;
    int    angle [NUM_POTS];
    int    spin  [NUM_POTS];
    item_t stim_q [$];

    dual_gang_pot_quadrant_decoder_core dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    dgpq_decode_check decode_check
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending      (pending),
        .result_count (result_count),
        .reject_count (reject_count)
    );

    always #5 clk = ~clk;

    // Receiver: stall pattern per mode, plus one-shot long hold-off
    always @(negedge clk) begin
        rx_cycle++;
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end
        else if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left     = LONG_HOLD - 1;
            m_tready     <= 1'b0;
        end
        else begin
            case (stall_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 3) != 0);
                2:       m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= ((rx_cycle % 7) > 2);
            endcase
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL dual_gang_pot_quadrant_decoder_core");
            $finish;
        end
    end

    function automatic item_t mk(logic [OP_W-1:0] op, int idx, int a1, int a2, int nv);
        item_t it;
        it.op          = op;
        it.pot_index   = idx[IDX_W-1:0];
        it.adc1_sample = a1[ADC_W-1:0];
        it.adc2_sample = a2[ADC_W-1:0];
        it.new_value   = nv[VAL_W-1:0];
        return it;
    endfunction

    // Triangle wave over one turn, full ADC swing
    function automatic logic [ADC_W-1:0] triangle_level(int a);
        int t;
        t = a % TURN_PERIOD;
        return (t < TURN_PERIOD / 2) ? ADC_W'(t / 2) : ADC_W'((TURN_PERIOD - 1 - t) / 2);
    endfunction

    // Mostly smooth turning of a pot, with set, load, unused op, bad index and noise
    function automatic item_t next_random_item();
        item_t it;
        int    pick;
        int    idx;
        int    dist_len;

        idx            = $urandom_range(0, NUM_POTS - 1);
        it.op          = OP_SAMPLE;
        it.pot_index   = idx[IDX_W-1:0];
        it.adc1_sample = ADC_W'($urandom);
        it.adc2_sample = ADC_W'($urandom);
        it.new_value   = VAL_W'($urandom);
        pick           = $urandom_range(0, 99);
        if (pick < 70) begin
            if ($urandom_range(0, 19) == 0)
                spin[idx] = -spin[idx];
            dist_len   = $urandom_range(0, 250);
            angle[idx] = (angle[idx] + spin[idx] * dist_len + TURN_PERIOD) % TURN_PERIOD;
            it.adc1_sample = triangle_level(angle[idx]);
            it.adc2_sample = triangle_level(angle[idx] + TURN_PERIOD / 4);
        end
        else if (pick < 78) begin
            it.op = OP_SET;
            if (vmax_set >= vmin_set && $urandom_range(0, 1) == 1)
                it.new_value = VAL_W'(vmin_set + int'($urandom_range(0, vmax_set - vmin_set)));
        end
        else if (pick < 83) begin
            it.op = OP_LOAD;
        end
        else if (pick < 86) begin
            it.op = OP_UNUSED;
        end
        else if (pick < 93) begin
            it.op        = OP_W'($urandom_range(0, 3));
            it.pot_index = IDX_W'($urandom_range(NUM_POTS, 15));
        end
        return it;
    endfunction

    // Write all seven registers back to back, then release the channel
    task automatic configure(int a1h, int a2h, int dz1, int dz2, int vmin, int vmax, int stp);
        int vals [7];
        vals = '{a1h, a2h, dz1, dz2, vmin, vmax, stp};
        for (int i = 0; i < 7; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= CFG_DATA_W'(vals[i]);
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            cfg_writes++;
            @(negedge clk);
        end
        cfg_valid <= 1'b0;
        vmin_set = $signed(16'(vmin));
        vmax_set = $signed(16'(vmax));
    endtask

    // Send queued beats in bursts with random gaps
    task automatic drive_items();
        item_t it;
        int    burst_left;
        int    gap;

        burst_left = 0;
        while (stim_q.size() > 0) begin
            it = stim_q.pop_front();
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap > 0) begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
            burst_left--;
            s_tvalid <= 1'b1;
            s_tdata  <= {4'b0, it.new_value, it.adc2_sample, it.adc1_sample, it.pot_index};
            s_tuser  <= it.op;
            @(posedge clk);
            while (!s_tready)
                @(posedge clk);
            items_sent++;
            @(negedge clk);
        end
        s_tvalid <= 1'b0;
    endtask

    // Let every predicted result arrive, then a few quiet cycles
    task automatic drain();
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    initial begin
        foreach (angle[i]) begin
            angle[i] = $urandom_range(0, TURN_PERIOD - 1);
            spin[i]  = ($urandom_range(0, 1) == 1) ? 1 : -1;
        end
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed beats at reset settings
        stall_mode = 1;
        stim_q.push_back(mk(OP_SAMPLE, 0, 0, 4095, 0));       // Q1, channel 2 rises
        stim_q.push_back(mk(OP_SAMPLE, 0, 4095, 4095, 0));    // Q1 to Q2
        stim_q.push_back(mk(OP_SAMPLE, 0, 4095, 0, 0));       // Q3, inside channel 1 dead zone
        stim_q.push_back(mk(OP_SAMPLE, 0, 3000, 0, 0));       // Q3, channel 1 falls
        stim_q.push_back(mk(OP_SAMPLE, 0, 0, 100, 0));        // Q3 to Q4
        stim_q.push_back(mk(OP_SAMPLE, 0, 2047, 2047, 0));    // ties at both halves, Q4 to Q1
        stim_q.push_back(mk(OP_SAMPLE, 0, 2047, 2040, 0));    // tie on channel 1 only
        stim_q.push_back(mk(OP_SAMPLE, 0, 2055, 2040, 0));    // inside channel 1 dead zone
        stim_q.push_back(mk(OP_SAMPLE, 0, 1500, 3000, 0));
        stim_q.push_back(mk(OP_SET, 0, 0, 0, 500));           // set in range
        stim_q.push_back(mk(OP_SET, 0, 0, 0, -1));            // below min
        stim_q.push_back(mk(OP_SET, 0, 0, 0, 1001));          // above max
        stim_q.push_back(mk(OP_LOAD, 1, 4095, 4095, 32767));  // load above max, no range check
        stim_q.push_back(mk(OP_SAMPLE, 1, 4095, 3000, 0));
        stim_q.push_back(mk(OP_LOAD, 2, 0, 0, -32768));       // load below min
        stim_q.push_back(mk(OP_SAMPLE, 2, 0, 1000, 0));
        stim_q.push_back(mk(OP_LOAD, 3, 2000, 3000, 999));
        stim_q.push_back(mk(OP_SAMPLE, 3, 1000, 4000, 0));    // step to max
        stim_q.push_back(mk(OP_SAMPLE, 3, 1000, 4095, 0));    // clamp at max
        stim_q.push_back(mk(OP_SET, 0, 0, 0, 0));
        stim_q.push_back(mk(OP_SAMPLE, 0, 1500, 2500, 0));    // clamp at min
        stim_q.push_back(mk(OP_SAMPLE, 4, 4095, 4095, -1));   // bad index on each op
        stim_q.push_back(mk(OP_SET, 15, 0, 0, 10));
        stim_q.push_back(mk(OP_LOAD, 9, 100, 100, 10));
        stim_q.push_back(mk(OP_UNUSED, 15, 0, 0, 0));
        stim_q.push_back(mk(OP_UNUSED, 0, 4095, 4095, -1));   // unused op on a valid pot
        drive_items();
        drain();

        // Random phases across several settings, extremes included
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: configure(2047, 2047, 0, 0, -32768, 32767, 32767);
                1: configure(0, 4095, 4095, 4095, 0, 0, 0);
                2: configure(4095, 0, 1, 1, 100, -100, 7);      // min above max
                3: configure($urandom_range(0, 4095), $urandom_range(0, 4095),
                             $urandom_range(0, 4095), $urandom_range(0, 4095),
                             $urandom_range(0, 65535), $urandom_range(0, 65535),
                             $urandom_range(0, 32767));
                4: configure(2047, 2047, 16, 16, -500, 500, 3);
                default: configure(1500, 2600, 40, 8, -1000, -200, 50);
            endcase
            stall_mode = ph % 4;
            if (ph == 2 || ph == 4)
                long_hold_req = 1'b1;
            repeat (PHASE_ITEMS)
                stim_q.push_back(next_random_item());
            drive_items();
            drain();
        end

        repeat (10) @(posedge clk);
        $display("Run covered %0d input beats and %0d register writes over 7 settings.",
                 items_sent, cfg_writes);
        $display("Checked %0d result beats, %0d of them dead zone rejections.",
                 result_count, reject_count);
        if (fail_count == 0)
            $display("PASS dual_gang_pot_quadrant_decoder_core");
        else
            $display("FAIL dual_gang_pot_quadrant_decoder_core");
        $finish;
    end

endmodule
